FILE: rtl/ulf_pkg.sv
// Shared types and constants of the UTF-8 checked line framer.
`timescale 1ns / 1ps
`default_nettype none

package ulf_pkg;

  localparam int unsigned MaxLineBytes = 64;
  localparam int unsigned StoreDepth   = 64;
  localparam int unsigned AddrW        = $clog2(StoreDepth);
  localparam int unsigned FillW        = $clog2(StoreDepth + 1);

  localparam logic [7:0] Newline        = 8'h0A;
  localparam logic [7:0] CarriageReturn = 8'h0D;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [1:0] {
    KindByte     = 2'd0,
    KindOversize = 2'd1,
    KindBadUtf8  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StChkRd,
    StChkEv,
    StVerdict,
    StEmitRd,
    StEmitWr
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_wr;
    logic start_discard;
    logic end_discard;
    logic start_line;
    logic chk_step;
    logic ptr_clr;
    logic push_bad;
    logic emit_step;
  } ulf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic newline;
    logic discard;
    logic full;
    logic line_empty;
    logic ptr_last;
    logic utf_ok;
    logic out_free;
  } ulf_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ulf_ctrl.sv
// Controller state machine of the line framer.
`timescale 1ns / 1ps
`default_nettype none

module ulf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ulf_pkg::ulf_sts_t sts_i,
  output ulf_pkg::ulf_cmd_t     cmd_o
);
  import ulf_pkg::*;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == StIdle) && sts_i.out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (sts_i.newline) begin
            if (sts_i.discard) begin
              cmd_o.end_discard = 1'b1;
            end else begin
              cmd_o.start_line = 1'b1;
              if (!sts_i.line_empty) begin
                state_d = StChkRd;
              end
            end
          end else if (!sts_i.discard) begin
            if (sts_i.full) begin
              cmd_o.start_discard = 1'b1;
            end else begin
              cmd_o.store_wr = 1'b1;
            end
          end
        end
      end
      StChkRd: begin
        state_d = StChkEv;
      end
      StChkEv: begin
        cmd_o.chk_step = 1'b1;
        state_d        = sts_i.ptr_last ? StVerdict : StChkRd;
      end
      StVerdict: begin
        if (sts_i.utf_ok) begin
          cmd_o.ptr_clr = 1'b1;
          state_d       = StEmitRd;
        end else if (sts_i.out_free) begin
          cmd_o.push_bad = 1'b1;
          state_d        = StIdle;
        end
      end
      StEmitRd: begin
        state_d = StEmitWr;
      end
      StEmitWr: begin
        if (sts_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          state_d         = sts_i.ptr_last ? StIdle : StEmitRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ulf_dpath.sv
// Datapath of the line framer: line store, UTF-8 checker, counters, output register.
`timescale 1ns / 1ps
`default_nettype none

module ulf_dpath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [7:0]             rx_byte_i,
  input  wire ulf_pkg::ulf_cmd_t      cmd_i,
  output ulf_pkg::ulf_sts_t           sts_o,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic [1:0]                  event_kind_o,
  output logic [7:0]                  line_byte_o,
  output logic [5:0]                  byte_position_o,
  output logic                        run_last_o,
  output logic [31:0]                 oversize_total_o,
  output logic [31:0]                 bad_utf8_total_o
);
  import ulf_pkg::*;

  logic [7:0]       store_mem [StoreDepth];
  logic [7:0]       rdata_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic             last_cr_q, last_cr_d;
  logic             discard_q, discard_d;
  logic [FillW-1:0] len_q, len_d;
  logic [FillW-1:0] line_len;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [31:0]      oversize_q, oversize_d;
  logic [31:0]      bad_q, bad_d;
  logic [1:0]       need_q, need_d;
  logic [7:0]       lo_q, lo_d;
  logic [7:0]       hi_q, hi_d;
  logic             err_q, err_d;
  logic             out_valid_q, out_valid_d;
  kind_e            out_kind_q;
  logic [7:0]       out_byte_q;
  logic [5:0]       out_pos_q;
  logic             out_last_q;
  logic             out_free;
  logic             ptr_last;

  // Store write in the idle state and one registered read every cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      store_mem[fill_q[AddrW-1:0]] <= rx_byte_i;
    end
    rdata_q <= store_mem[ptr_q];
  end

  // A trailing carriage return is dropped from the length at the newline.
  assign line_len = fill_q - FillW'(last_cr_q && (fill_q != '0));
  assign ptr_last = ({1'b0, ptr_q} == (len_q - FillW'(1)));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    fill_d    = fill_q;
    last_cr_d = last_cr_q;
    discard_d = discard_q;
    len_d     = len_q;
    ptr_d     = ptr_q;
    oversize_d = oversize_q;
    bad_d     = bad_q;
    need_d    = need_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    err_d     = err_q;
    if (cmd_i.store_wr) begin
      fill_d    = fill_q + FillW'(1);
      last_cr_d = (rx_byte_i == CarriageReturn);
    end
    if (cmd_i.start_discard) begin
      discard_d  = 1'b1;
      fill_d     = '0;
      oversize_d = oversize_q + 32'd1;
    end
    if (cmd_i.end_discard) begin
      discard_d = 1'b0;
      fill_d    = '0;
    end
    if (cmd_i.start_line) begin
      len_d  = line_len;
      fill_d = '0;
      ptr_d  = '0;
      need_d = 2'd0;
      err_d  = 1'b0;
      lo_d   = 8'h80;
      hi_d   = 8'hBF;
    end
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end
    if (cmd_i.push_bad) begin
      bad_d = bad_q + 32'd1;
    end
    if (cmd_i.emit_step) begin
      ptr_d = ptr_q + AddrW'(1);
    end
    if (cmd_i.chk_step) begin
      ptr_d = ptr_q + AddrW'(1);
      if (need_q == 2'd0) begin
        lo_d = 8'h80;
        hi_d = 8'hBF;
        unique case (rdata_q) inside
          [8'h00:8'h7F]: need_d = 2'd0;
          [8'hC2:8'hDF]: need_d = 2'd1;
          8'hE0: begin
            need_d = 2'd2;
            lo_d   = 8'hA0;
          end
          8'hED: begin
            need_d = 2'd2;
            hi_d   = 8'h9F;
          end
          [8'hE1:8'hEC], 8'hEE, 8'hEF: need_d = 2'd2;
          8'hF0: begin
            need_d = 2'd3;
            lo_d   = 8'h90;
          end
          [8'hF1:8'hF3]: need_d = 2'd3;
          8'hF4: begin
            need_d = 2'd3;
            hi_d   = 8'h8F;
          end
          default: err_d = 1'b1;
        endcase
      end else begin
        // The first continuation byte carries the overlong, surrogate and range limits.
        if ((rdata_q < lo_q) || (rdata_q > hi_q)) begin
          err_d = 1'b1;
        end
        need_d = need_q - 2'd1;
        lo_d   = 8'h80;
        hi_d   = 8'hBF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      last_cr_q  <= 1'b0;
      discard_q  <= 1'b0;
      len_q      <= '0;
      ptr_q      <= '0;
      oversize_q <= '0;
      bad_q      <= '0;
      need_q     <= 2'd0;
      lo_q       <= 8'h80;
      hi_q       <= 8'hBF;
      err_q      <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      last_cr_q  <= last_cr_d;
      discard_q  <= discard_d;
      len_q      <= len_d;
      ptr_q      <= ptr_d;
      oversize_q <= oversize_d;
      bad_q      <= bad_d;
      need_q     <= need_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      err_q      <= err_d;
    end
  end

  // Output register: one beat held until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.start_discard || cmd_i.push_bad || cmd_i.emit_step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_discard) begin
      out_kind_q <= KindOversize;
      out_byte_q <= 8'h00;
      out_pos_q  <= 6'd0;
      out_last_q <= 1'b1;
    end else if (cmd_i.push_bad) begin
      out_kind_q <= KindBadUtf8;
      out_byte_q <= 8'h00;
      out_pos_q  <= 6'd0;
      out_last_q <= 1'b1;
    end else if (cmd_i.emit_step) begin
      out_kind_q <= KindByte;
      out_byte_q <= rdata_q;
      out_pos_q  <= 6'(ptr_q);
      out_last_q <= ptr_last;
    end
  end

  // The counters only move together with a new beat, which needs a free
  // output slot, so a held beat always sees the totals of its own step.
  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = out_kind_q;
  assign line_byte_o      = out_byte_q;
  assign byte_position_o  = out_pos_q;
  assign run_last_o       = out_last_q;
  assign oversize_total_o = oversize_q;
  assign bad_utf8_total_o = bad_q;

  assign sts_o.newline    = (rx_byte_i == Newline);
  assign sts_o.discard    = discard_q;
  assign sts_o.full       = (fill_q >= FillW'(MaxLineBytes));
  assign sts_o.line_empty = (line_len == '0);
  assign sts_o.ptr_last   = ptr_last;
  assign sts_o.utf_ok     = !err_q && (need_q == 2'd0);
  assign sts_o.out_free   = out_free;

  a_store_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_wr |-> (fill_q < FillW'(MaxLineBytes)))
    else $error("store written while full");

  a_push_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start_discard || cmd_i.push_bad || cmd_i.emit_step) |-> out_free)
    else $error("beat pushed over an unsent beat");

  a_walk_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.chk_step || cmd_i.emit_step) |-> ({1'b0, ptr_q} < len_q))
    else $error("store walk beyond line length");

  a_oversize_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_discard |=> (oversize_q == $past(oversize_q) + 32'd1) && discard_q)
    else $error("oversize drop not counted");

endmodule

`default_nettype wire

FILE: rtl/utf8_checked_line_framer.sv
// Top level of the UTF-8 checked line framer.
//
// Input stream: one received byte per beat on s_axis_tdata_i. Bytes are
// collected until a newline; one trailing carriage return is removed and
// empty lines yield nothing. Output stream: a valid line goes out one byte
// per beat with tlast on its final byte; tuser gives the event kind (line
// byte, line dropped as oversize, line dropped as invalid UTF-8). A drop is
// a single beat with tlast set. tdata also carries the two wrapping totals.
// A newline that closes a line holds off the input while the line store,
// which has one read port, is walked through the UTF-8 checker and, for a
// valid line, once more for emission, each byte taking a read state and a
// use state. The oversize beat leaves in the cycle after the byte that
// caused it. All results sit in one output
// register; while the receiver stalls, emission waits and the input is held
// off for as long as an unsent beat waits in that register. Reset clears the
// counters, the fill count and the drop state; the line store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module utf8_checked_line_framer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [ulf_pkg::InDataW-1:0]   s_axis_tdata_i,  // [7:0] rx_byte
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [7:0] line_byte, [13:8] byte_position, [45:14] oversize_total,
  // [77:46] bad_utf8_total, [79:78] zero
  output logic [ulf_pkg::OutDataW-1:0]       m_axis_tdata_o,
  output logic                               m_axis_tlast_o,  // run_last
  output logic [1:0]                         m_axis_tuser_o   // [1:0] event_kind
);
  import ulf_pkg::*;

  ulf_cmd_t    cmd;
  ulf_sts_t    sts;
  logic [7:0]  line_byte;
  logic [5:0]  byte_position;
  logic [31:0] oversize_total;
  logic [31:0] bad_utf8_total;

  ulf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ulf_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (s_axis_tdata_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .event_kind_o     (m_axis_tuser_o),
    .line_byte_o      (line_byte),
    .byte_position_o  (byte_position),
    .run_last_o       (m_axis_tlast_o),
    .oversize_total_o (oversize_total),
    .bad_utf8_total_o (bad_utf8_total)
  );

  assign m_axis_tdata_o = {2'b00, bad_utf8_total, oversize_total, byte_position, line_byte};

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking stream testbench for the UTF-8 checked line framer.
`timescale 1ns / 1ps

module testbench;
  import ulf_pkg::*;

  typedef struct {
    kind_e       kind;
    logic [7:0]  data;
    logic [5:0]  pos;
    logic        last;
    logic [31:0] oversize;
    logic [31:0] bad_utf8;
  } line_event_t;

  typedef enum int {
    FlawOverlong2,
    FlawOverlong3,
    FlawOverlong4,
    FlawSurrogate,
    FlawAboveMax,
    FlawBadLead,
    FlawStrayCont,
    FlawShortSeq,
    FlawTruncated
  } flaw_e;

  localparam int unsigned LongHold  = 400;
  localparam int unsigned DrainWait = 300;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data  = '0;
  logic                m_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic [1:0]          m_axis_tuser_o;

  // Bytes waiting to be sent and line events still to be seen on the output.
  logic [7:0]  rx_backlog[$];
  line_event_t line_events[$];

  // Shadow state of the framer.
  logic [7:0]  shadow_line[StoreDepth];
  int unsigned shadow_fill     = 0;
  bit          shadow_dropping = 1'b0;
  logic [31:0] shadow_oversize = '0;
  logic [31:0] shadow_bad      = '0;

  int unsigned errors         = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned lines_ok       = 0;
  int unsigned line_bytes_ok  = 0;
  int unsigned burst_left     = 1;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned stall_left     = 0;
  int unsigned phase_left     = 0;
  bit          calm           = 1'b1;

  utf8_checked_line_framer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d line events outstanding", line_events.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    errors++;
  endtask

  function automatic void push_event(kind_e kind, logic [7:0] data, int unsigned pos,
                                     logic last);
    line_event_t ev;
    ev.kind     = kind;
    ev.data     = data;
    ev.pos      = pos[5:0];
    ev.last     = last;
    ev.oversize = shadow_oversize;
    ev.bad_utf8 = shadow_bad;
    line_events.push_back(ev);
  endfunction

  // Strict UTF-8 over the first len bytes of the shadow line.
  function automatic bit utf8_valid(int unsigned len);
    int unsigned p;
    int unsigned more;
    logic [31:0] cp;
    logic [7:0]  lead;
    logic [7:0]  c;
    p = 0;
    while (p < len) begin
      lead = shadow_line[p];
      p++;
      if (lead <= 8'h7F) continue;
      if (lead >= 8'hC2 && lead <= 8'hDF) begin
        cp = lead & 8'h1F;
        more = 1;
      end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
        cp = lead & 8'h0F;
        more = 2;
      end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
        cp = lead & 8'h07;
        more = 3;
      end else begin
        return 1'b0;
      end
      if (p + more > len) return 1'b0;
      for (int unsigned k = 0; k < more; k++) begin
        c = shadow_line[p];
        p++;
        if ((c & 8'hC0) != 8'h80) return 1'b0;
        cp = (cp << 6) | (c & 8'h3F);
      end
      if ((more == 2 && cp < 32'h800) || (more == 3 && cp < 32'h10000) ||
          (cp >= 32'hD800 && cp <= 32'hDFFF) || cp > 32'h10FFFF)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the shadow framer by one received byte and queues what it emits.
  function automatic void frame_rx_byte(logic [7:0] b);
    int unsigned len;
    if (b == Newline) begin
      if (shadow_dropping) begin
        shadow_dropping = 1'b0;
        shadow_fill = 0;
        return;
      end
      len = shadow_fill;
      if (len > 0 && shadow_line[len-1] == CarriageReturn) len--;
      shadow_fill = 0;
      if (len == 0) return;
      if (!utf8_valid(len)) begin
        shadow_bad++;
        push_event(KindBadUtf8, 8'h00, 0, 1'b1);
        return;
      end
      for (int unsigned i = 0; i < len; i++)
        push_event(KindByte, shadow_line[i], i, i + 1 == len);
      lines_ok++;
      line_bytes_ok += len;
      return;
    end
    if (shadow_dropping) return;
    if (shadow_fill >= MaxLineBytes) begin
      shadow_dropping = 1'b1;
      shadow_fill = 0;
      shadow_oversize++;
      push_event(KindOversize, 8'h00, 0, 1'b1);
      return;
    end
    shadow_line[shadow_fill] = b;
    shadow_fill++;
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Appends one well-formed character of cls bytes with a random code point.
  task automatic put_char(int unsigned cls);
    logic [20:0] cp;
    logic [7:0]  a;
    case (cls)
      1: begin
        a = 8'($urandom_range(0, 127));
        if (a == Newline) a = CarriageReturn;
        rx_backlog.push_back(a);
      end
      2: begin
        cp = 21'($urandom_range('h80, 'h7FF));
        rx_backlog.push_back({3'b110, cp[10:6]});
        rx_backlog.push_back({2'b10, cp[5:0]});
      end
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
        rx_backlog.push_back({4'b1110, cp[15:12]});
        rx_backlog.push_back({2'b10, cp[11:6]});
        rx_backlog.push_back({2'b10, cp[5:0]});
      end
      default: begin
        cp = 21'($urandom_range('h10000, 'h10FFFF));
        rx_backlog.push_back({5'b11110, cp[20:18]});
        rx_backlog.push_back({2'b10, cp[17:12]});
        rx_backlog.push_back({2'b10, cp[11:6]});
        rx_backlog.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Appends well-formed text of exactly n bytes.
  task automatic put_text(int unsigned n);
    int unsigned used;
    int unsigned cls;
    used = 0;
    while (used < n) begin
      cls = $urandom_range(1, 4);
      if (cls > n - used) cls = 1;
      put_char(cls);
      used += cls;
    end
  endtask

  task automatic put_flaw(flaw_e f);
    logic [7:0]  lead;
    int unsigned more;
    case (f)
      FlawOverlong2: begin
        rx_backlog.push_back(8'($urandom_range('hC0, 'hC1)));
        rx_backlog.push_back(cont_byte());
      end
      FlawOverlong3: begin
        rx_backlog.push_back(8'hE0);
        rx_backlog.push_back(8'($urandom_range('h80, 'h9F)));
        rx_backlog.push_back(cont_byte());
      end
      FlawOverlong4: begin
        rx_backlog.push_back(8'hF0);
        rx_backlog.push_back(8'($urandom_range('h80, 'h8F)));
        rx_backlog.push_back(cont_byte());
        rx_backlog.push_back(cont_byte());
      end
      FlawSurrogate: begin
        rx_backlog.push_back(8'hED);
        rx_backlog.push_back(8'($urandom_range('hA0, 'hBF)));
        rx_backlog.push_back(cont_byte());
      end
      FlawAboveMax: begin
        rx_backlog.push_back(8'hF4);
        rx_backlog.push_back(8'($urandom_range('h90, 'hBF)));
        rx_backlog.push_back(cont_byte());
        rx_backlog.push_back(cont_byte());
      end
      FlawBadLead:   rx_backlog.push_back(8'($urandom_range('hF5, 'hFF)));
      FlawStrayCont: rx_backlog.push_back(cont_byte());
      FlawShortSeq: begin
        rx_backlog.push_back(8'($urandom_range('hC2, 'hF4)));
        rx_backlog.push_back(8'($urandom_range('h20, 'h7E)));
      end
      default: begin
        // A sequence that the end of the line cuts short.
        lead = 8'($urandom_range('hC2, 'hF4));
        more = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
        rx_backlog.push_back(lead);
        repeat ($urandom_range(0, more - 1)) rx_backlog.push_back(cont_byte());
      end
    endcase
  endtask

  task automatic end_line(bit with_cr);
    if (with_cr) rx_backlog.push_back(CarriageReturn);
    rx_backlog.push_back(Newline);
  endtask

  task automatic put_bytes(input logic [7:0] bytes[]);
    foreach (bytes[i]) rx_backlog.push_back(bytes[i]);
  endtask

  initial begin
    int unsigned len;
    int unsigned shape;
    flaw_e       flaw;

    for (int i = 0; i < StoreDepth; i++) shadow_line[i] = '0;

    // Empty lines, carriage returns and a few hand-picked sequences.
    put_bytes('{Newline});
    put_bytes('{CarriageReturn, Newline});
    put_bytes('{8'h41, CarriageReturn, CarriageReturn, Newline});
    put_bytes('{8'h00, 8'hFF, Newline});
    put_bytes('{8'hE2, 8'h82, Newline});
    put_bytes('{8'hED, 8'hA0, 8'h80, Newline});
    put_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F, Newline});

    // A line that fills the store exactly, then one whose carriage return
    // finds the store full.
    put_text(MaxLineBytes);
    end_line(1'b0);
    put_text(MaxLineBytes);
    end_line(1'b1);

    // Random lines until about two hundred bytes are queued in all.
    while (rx_backlog.size() < 200) begin
      shape = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 72) : $urandom_range(0, 12);
      if (shape < 70) begin
        put_text(len);
        end_line($urandom_range(0, 2) == 0);
      end else if (shape < 85) begin
        put_text($urandom_range(0, 6));
        flaw = flaw_e'($urandom_range(0, FlawTruncated));
        put_flaw(flaw);
        if (flaw != FlawTruncated) put_text($urandom_range(0, 6));
        end_line($urandom_range(0, 2) == 0);
      end else begin
        repeat ($urandom_range(1, 10)) rx_backlog.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) rx_backlog.push_back(Newline);
      end
    end

    do @(negedge clk_i);
    while (rx_backlog.size() != 0 || s_valid || line_events.size() != 0);
    repeat (DrainWait) @(negedge clk_i);

    if (line_events.size() != 0)
      flag_mismatch($sformatf("%0d line events never arrived", line_events.size()));
    $display("Sent %0d bytes; %0d lines came out whole (%0d bytes), %0d were too long,",
             bytes_accepted, lines_ok, line_bytes_ok, shadow_oversize);
    $display("%0d failed UTF-8; %0d output beats checked.", shadow_bad, results_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        frame_rx_byte(s_data);
        bytes_accepted++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (rx_backlog.size() > 0) begin
          s_valid <= 1'b1;
          s_data  <= rx_backlog.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure: calm stretches, short random stalls, and one
  // long hold-off so that the framer fills up and stalls its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 20) begin
      hold_done = 1'b1;
      hold_left = LongHold;
      m_ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        phase_left = $urandom_range(20, 200);
      end else begin
        phase_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Output checker.
  always @(posedge clk_i) begin
    line_event_t ev;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      results_seen <= results_seen + 1;
      if (line_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind %0d data %h", m_axis_tuser_o,
                                m_axis_tdata_o));
      end else begin
        ev = line_events.pop_front();
        if (m_axis_tuser_o !== ev.kind)
          flag_mismatch($sformatf("kind %0d, expected %0d", m_axis_tuser_o, ev.kind));
        if (m_axis_tdata_o[7:0] !== ev.data)
          flag_mismatch($sformatf("line byte %h, expected %h", m_axis_tdata_o[7:0],
                                  ev.data));
        if (m_axis_tdata_o[13:8] !== ev.pos)
          flag_mismatch($sformatf("position %0d, expected %0d", m_axis_tdata_o[13:8],
                                  ev.pos));
        if (m_axis_tlast_o !== ev.last)
          flag_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast_o, ev.last));
        if (m_axis_tdata_o[45:14] !== ev.oversize)
          flag_mismatch($sformatf("oversize total %0d, expected %0d",
                                  m_axis_tdata_o[45:14], ev.oversize));
        if (m_axis_tdata_o[77:46] !== ev.bad_utf8)
          flag_mismatch($sformatf("bad UTF-8 total %0d, expected %0d",
                                  m_axis_tdata_o[77:46], ev.bad_utf8));
        if (m_axis_tdata_o[79:78] !== 2'b00)
          flag_mismatch($sformatf("padding bits %b, expected zero", m_axis_tdata_o[79:78]));
      end
    end
  end

endmodule
